// ===== rtl/gdc_pkg.sv =====
// Shared types, constants and register indexes of the depth-first connectivity block.
package gdc_pkg;

  localparam int MaxNodes  = 32;
  localparam int MaxDegree = 32;
  localparam int NodeLimit = (MaxNodes < 32) ? MaxNodes : 32;

  localparam int NodeW   = 5;                         // vertex number field
  localparam int SlotW   = $clog2(MaxDegree);         // slot within a neighbor list
  localparam int DegW    = $clog2(MaxDegree + 1);     // degree count
  localparam int DepthW  = $clog2(MaxNodes + 1);      // stack depth, visit total
  localparam int CntW    = 6;                         // node_count register
  localparam int CfgW    = 6;                         // widest register
  localparam int AdjW    = NodeW + SlotW;             // neighbor memory address
  localparam int AdjDepth = MaxNodes * MaxDegree;

  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgStartNode = 1'b1;

  localparam logic CmdAddEdge = 1'b0;
  localparam logic CmdRun     = 1'b1;

  localparam logic StatVisit  = 1'b0;
  localparam logic StatReject = 1'b1;

  typedef struct packed {
    logic             command;
    logic [NodeW-1:0] from_node;
    logic [NodeW-1:0] to_node;
  } edge_req_t;

  typedef struct packed {
    logic             status;
    logic [NodeW-1:0] visited_node;
    logic [NodeW-1:0] visit_index;
    logic             is_last;
    logic             connected;
  } result_t;

  typedef struct packed {
    logic add_edge;    // append edge to its source list
    logic reject;      // emit a rejection (edge or bad start)
    logic run_begin;   // clear marks, visit start vertex
    logic fetch;       // read next neighbor of stack top, advance its position
    logic pop;         // drop stack top
    logic visit;       // visit fetched neighbor
    logic finish;      // flush last report with is_last and connected
    logic clear_lists; // zero all degree counts
  } ctrl_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic start_ok;
    logic has_next;
    logic last_pop;
    logic can_visit;
  } ctrl_sts_t;

endpackage

// ===== rtl/gdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gdc_ctrl.sv =====
// Sequencer of the depth-first walk: decides each cycle's datapath command.
module gdc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                command_i,
  input  gdc_pkg::ctrl_sts_t  sts_i,
  output gdc_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy
);
  import gdc_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StFetch
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          if (command_i == CmdAddEdge) begin
            if (sts_i.edge_ok) begin
              cmd_o.add_edge = 1'b1;
            end else begin
              cmd_o.reject = 1'b1;
            end
          end else if (sts_i.start_ok) begin
            cmd_o.run_begin = 1'b1;
            state_d         = StCheck;
          end else begin
            cmd_o.reject      = 1'b1;
            cmd_o.clear_lists = 1'b1;
          end
        end
      end
      StCheck: begin
        if (sts_i.has_next) begin
          cmd_o.fetch = 1'b1;
          state_d     = StFetch;
        end else begin
          cmd_o.pop = 1'b1;
          if (sts_i.last_pop) begin
            cmd_o.finish      = 1'b1;
            cmd_o.clear_lists = 1'b1;
            state_d           = StIdle;
          end
        end
      end
      StFetch: begin
        cmd_o.visit = sts_i.can_visit;
        state_d     = StCheck;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    busy_d = (state_d != StIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

endmodule

// ===== rtl/gdc_dpath.sv =====
// Datapath: registers, degree counts, visited marks, walk stack, neighbor memory, results.
module gdc_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gdc_pkg::ctrl_cmd_t          cmd_i,
  output gdc_pkg::ctrl_sts_t          sts_o,
  input  gdc_pkg::edge_req_t          req_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gdc_pkg::CfgW-1:0]    cfg_data_i,
  output logic                        res_valid_o,
  output gdc_pkg::result_t            res_o
);
  import gdc_pkg::*;

  logic [CntW-1:0]   node_count_q, node_count_d;
  logic [NodeW-1:0]  start_node_q, start_node_d;
  logic [DegW-1:0]   deg_q [MaxNodes];
  logic [DegW-1:0]   deg_d [MaxNodes];
  logic [MaxNodes-1:0] visited_q, visited_d;
  logic [NodeW-1:0]  stk_node_q [MaxNodes];
  logic [NodeW-1:0]  stk_node_d [MaxNodes];
  logic [DegW-1:0]   stk_pos_q [MaxNodes];
  logic [DegW-1:0]   stk_pos_d [MaxNodes];
  logic [DepthW-1:0] depth_q, depth_d;
  logic [DepthW-1:0] total_q, total_d;
  logic [NodeW-1:0]  pend_node_q, pend_node_d;
  logic [NodeW-1:0]  pend_idx_q, pend_idx_d;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;

  logic [CntW-1:0]   live_n;
  logic [NodeW-1:0]  top_idx;
  logic [NodeW-1:0]  push_idx;
  logic [NodeW-1:0]  top_node;
  logic [DegW-1:0]   top_pos;
  logic [NodeW-1:0]  nbr;
  logic [AdjW-1:0]   waddr;
  logic [AdjW-1:0]   raddr;

  // Clamp node_count into 1..NodeLimit.
  always_comb begin
    if (node_count_q == '0) begin
      live_n = CntW'(1);
    end else if (node_count_q > CntW'(NodeLimit)) begin
      live_n = CntW'(NodeLimit);
    end else begin
      live_n = node_count_q;
    end
  end

  assign top_idx  = depth_q[NodeW-1:0] - NodeW'(1);
  assign push_idx = depth_q[NodeW-1:0];
  assign top_node = stk_node_q[top_idx];
  assign top_pos  = stk_pos_q[top_idx];

  assign waddr = {req_i.from_node, deg_q[req_i.from_node][SlotW-1:0]};
  assign raddr = {top_node, top_pos[SlotW-1:0]};

  gdc_ram #(
    .Width (NodeW),
    .Depth (AdjDepth)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_edge),
    .waddr_i (waddr),
    .wdata_i (req_i.to_node),
    .raddr_i (raddr),
    .rdata_o (nbr)
  );

  always_comb begin
    sts_o.edge_ok   = ({1'b0, req_i.from_node} < live_n)
                   && ({1'b0, req_i.to_node} < live_n)
                   && (deg_q[req_i.from_node] < DegW'(MaxDegree));
    sts_o.start_ok  = ({1'b0, start_node_q} < live_n);
    sts_o.has_next  = (top_pos < deg_q[top_node]);
    sts_o.last_pop  = (depth_q == DepthW'(1));
    sts_o.can_visit = ({1'b0, nbr} < live_n) && !visited_q[nbr]
                   && (depth_q < DepthW'(MaxNodes));
  end

  always_comb begin
    node_count_d = node_count_q;
    start_node_d = start_node_q;
    deg_d        = deg_q;
    visited_d    = visited_q;
    stk_node_d   = stk_node_q;
    stk_pos_d    = stk_pos_q;
    depth_d      = depth_q;
    total_d      = total_q;
    pend_node_d  = pend_node_q;
    pend_idx_d   = pend_idx_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNodeCount: node_count_d = cfg_data_i[CntW-1:0];
        CfgStartNode: start_node_d = cfg_data_i[NodeW-1:0];
        default: ;
      endcase
    end

    if (cmd_i.add_edge) begin
      deg_d[req_i.from_node] = deg_q[req_i.from_node] + DegW'(1);
    end

    if (cmd_i.reject) begin
      res_valid_d = 1'b1;
      res_d       = '{status: StatReject, visited_node: '0, visit_index: '0,
                      is_last: 1'b1, connected: 1'b0};
    end

    if (cmd_i.run_begin) begin
      visited_d               = '0;
      visited_d[start_node_q] = 1'b1;
      stk_node_d[0]           = start_node_q;
      stk_pos_d[0]            = '0;
      depth_d                 = DepthW'(1);
      total_d                 = DepthW'(1);
      pend_node_d             = start_node_q;
      pend_idx_d              = '0;
    end

    if (cmd_i.fetch) begin
      stk_pos_d[top_idx] = top_pos + DegW'(1);
    end

    if (cmd_i.pop) begin
      depth_d = depth_q - DepthW'(1);
    end

    // Report the held visit, then hold the new one until the next visit or the end.
    if (cmd_i.visit) begin
      res_valid_d          = 1'b1;
      res_d                = '{status: StatVisit, visited_node: pend_node_q,
                               visit_index: pend_idx_q, is_last: 1'b0, connected: 1'b0};
      visited_d[nbr]       = 1'b1;
      stk_node_d[push_idx] = nbr;
      stk_pos_d[push_idx]  = '0;
      depth_d              = depth_q + DepthW'(1);
      total_d              = total_q + DepthW'(1);
      pend_node_d          = nbr;
      pend_idx_d           = total_q[NodeW-1:0];
    end

    if (cmd_i.finish) begin
      res_valid_d = 1'b1;
      res_d       = '{status: StatVisit, visited_node: pend_node_q,
                      visit_index: pend_idx_q, is_last: 1'b1,
                      connected: (total_q == DepthW'(live_n))};
    end

    if (cmd_i.clear_lists) begin
      for (int k = 0; k < MaxNodes; k++) begin
        deg_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CntW'(MaxNodes);
      start_node_q <= '0;
      for (int k = 0; k < MaxNodes; k++) begin
        deg_q[k] <= '0;
      end
      visited_q   <= '0;
      depth_q     <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      node_count_q <= node_count_d;
      start_node_q <= start_node_d;
      deg_q        <= deg_d;
      visited_q    <= visited_d;
      depth_q      <= depth_d;
      total_q      <= total_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stk_node_q  <= stk_node_d;
    stk_pos_q   <= stk_pos_d;
    pend_node_q <= pend_node_d;
    pend_idx_q  <= pend_idx_d;
    res_q       <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/graph_dfs_connectivity.sv =====
// Top level of the directed-graph depth-first connectivity checker.
//
//   channel   | ports                              | handshake
//   ----------+------------------------------------+-------------------------------
//   request   | start, busy, req_i                 | taken when start=1 and busy=0
//   result    | res_valid_o, res_o                 | one cycle per result, no stall
//   config    | cfg_we_i, cfg_idx_i, cfg_data_i    | written when cfg_we_i=1
//
// For an add-edge request busy stays low, so edges stream one per
// cycle and a rejection appears on the result port the cycle after the request.
// A run request visits the start vertex, then fetches each neighbor of the stack top
// through the registered read port of the neighbor RAM, and pops finished vertices.
// Each visit report leaves one visit late; the last leaves the cycle after the
// final pop, with is_last and connected set. Reset needs no clearing pass: degree
// counts and visited marks are flip-flops cleared at once, and the neighbor RAM
// is only read below a vertex's degree. The receiver cannot stall results.
module graph_dfs_connectivity (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  gdc_pkg::edge_req_t       req_i,
  output logic                     res_valid_o,
  output gdc_pkg::result_t         res_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [gdc_pkg::CfgW-1:0] cfg_data_i
);
  import gdc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequence the walk: request decode, neighbor fetch, visit, pop.
  gdc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (req_i.command),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // Hold graph state, stack and result register.
  gdc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
